[design/ppsp_pkg.sv]
// Shared types and constants for the PAT/PMT section parser.
package ppsp_pkg;

    localparam int DEF_MAX_SECTION_BYTES = 1024;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_PROGRAM = 2'd0;
    localparam logic [1:0] KIND_NETWORK = 2'd1;
    localparam logic [1:0] KIND_STREAM  = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam int PAT_FIRST_ENTRY_END = 11;
    localparam int PMT_INFO_LEN_POS    = 11;
    localparam int PMT_HEADER_BYTES    = 12;
    localparam int ES_HEADER_BYTES     = 5;
    localparam int CRC_BYTES           = 4;
    localparam int ES_PID_OFFSET       = 2;
    localparam int ES_LEN_OFFSET       = 4;
    localparam logic [7:0] COUNT_MAX   = 8'hff;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [10:0] section_size;
        logic [12:0] table_pid;
    } item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] entry_number;
        logic [12:0] entry_pid;
        logic [7:0]  program_total;
        logic        overrun_error;
    } result_t;

endpackage

[design/ppsp_front.sv]
// Front end: takes section bytes, tracks position and entries, emits results.
module ppsp_front #(
    parameter int MAX_SECTION_BYTES = ppsp_pkg::DEF_MAX_SECTION_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ppsp_pkg::item_t   item,
    input  logic              space,
    output logic              push,
    output ppsp_pkg::result_t push_data
);
    import ppsp_pkg::*;

    localparam int PW = $clog2(MAX_SECTION_BYTES);
    localparam int NW = $clog2(MAX_SECTION_BYTES + 4105);

    logic [PW-1:0] pos_reg, pos_next;
    logic [31:0]   held_reg, held_next;
    logic [NW-1:0] nes_reg, nes_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic          err_reg, err_next;

    logic          accept;
    logic          is_pat;
    logic          emit;
    logic [NW-1:0] eff, last, pos_w, off, es_len;
    result_t       res;

    assign item_ready = space;
    assign accept     = item_valid && item_ready;
    assign is_pat     = (item.table_pid == 13'd0);
    assign held_next  = {held_reg[23:0], item.data_byte};
    assign pos_w      = NW'(pos_reg);
    assign es_len     = NW'(held_next[11:0]);
    assign off        = pos_w - nes_reg;

    always_comb
    begin
        if (NW'(item.section_size) > NW'(MAX_SECTION_BYTES))
            eff = NW'(MAX_SECTION_BYTES);
        else if (item.section_size == 11'd0)
            eff = NW'(1);
        else
            eff = NW'(item.section_size);
        last = eff - NW'(1);
    end

    always_comb
    begin
        nes_next = nes_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;
        emit     = 1'b0;
        res      = '0;
        if (is_pat) begin
            if (pos_w >= NW'(PAT_FIRST_ENTRY_END) && pos_reg[1:0] == 2'b11 && pos_w < last)
            begin
                emit             = 1'b1;
                res.entry_number = held_next[31:16];
                res.entry_pid    = held_next[12:0];
                res.result_kind  = (held_next[31:16] == 16'd0) ? KIND_NETWORK : KIND_PROGRAM;
                if (held_next[31:16] != 16'd0 && cnt_reg != COUNT_MAX)
                    cnt_next = cnt_reg + 8'd1;
            end
        end else begin
            if (pos_w == NW'(PMT_INFO_LEN_POS)) begin
                nes_next = NW'(PMT_HEADER_BYTES) + es_len;
                if (nes_next >= eff)
                    err_next = 1'b1;
            end else if (pos_w >= NW'(PMT_HEADER_BYTES) && nes_reg + NW'(CRC_BYTES) < eff &&
                         pos_w >= nes_reg)
            begin
                if (off == NW'(ES_PID_OFFSET)) begin
                    emit             = 1'b1;
                    res.result_kind  = KIND_STREAM;
                    res.entry_number = {8'd0, held_next[23:16]};
                    res.entry_pid    = held_next[12:0];
                end else if (off >= NW'(ES_LEN_OFFSET)) begin
                    nes_next = nes_reg + NW'(ES_HEADER_BYTES) + es_len;
                    if (nes_next >= eff)
                        err_next = 1'b1;
                end
            end
        end
        if (pos_w >= last) begin
            emit              = 1'b1;
            res               = '0;
            res.result_kind   = KIND_END;
            res.program_total = is_pat ? cnt_next : 8'd0;
            res.overrun_error = !is_pat && (err_next || pos_w < NW'(PMT_INFO_LEN_POS));
        end
        pos_next = pos_reg + PW'(1);
    end

    assign push      = accept && emit;
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg  <= '0;
            held_reg <= '0;
            nes_reg  <= '0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (accept) begin
            if (pos_w >= last) begin
                pos_reg  <= '0;
                held_reg <= '0;
                nes_reg  <= '0;
                cnt_reg  <= '0;
                err_reg  <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                held_reg <= held_next;
                nes_reg  <= nes_next;
                cnt_reg  <= cnt_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

[design/ppsp_queue.sv]
// Back end: short result queue that drives the output channel.
module ppsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppsp_pkg::result_t push_data,
    output logic              space,
    output logic              result_valid,
    input  logic              result_ready,
    output ppsp_pkg::result_t result
);
    import ppsp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    result_t       mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          pop;

    assign space        = (cnt_reg != (AW+1)'(QUEUE_DEPTH));
    assign result_valid = (cnt_reg != '0);
    assign pop          = result_valid && result_ready;
    assign result       = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wr_reg <= wr_reg + AW'(1);
            if (pop)
                rd_reg <= rd_reg + AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

endmodule

[design/psi_pat_pmt_section_parser_top.sv]
// Top level of the PAT/PMT section parser: front end plus result queue.
//
// channel  dir  handshake                   payload
// item     in   item_valid / item_ready     item   (data_byte, section_size, table_pid)
// result   out  result_valid / result_ready result (kind, number, pid, total, error)
//
// One byte per cycle while the queue has room; each result is queued with its byte.
// The byte beat is taken whenever the 4-entry result queue has room.
// Reset clears position, held bytes, entry offset, count and error flag.
// A stalled result side stalls the byte side only once the queue is full.
module psi_pat_pmt_section_parser_top #(
    parameter int MAX_SECTION_BYTES = ppsp_pkg::DEF_MAX_SECTION_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ppsp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output ppsp_pkg::result_t result
);
    import ppsp_pkg::*;

    logic    space;
    logic    push;
    result_t push_data;

    ppsp_front #(
        .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .space     (space),
        .push      (push),
        .push_data (push_data)
    );

    ppsp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (push_data),
        .space       (space),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule
